FILE: rtl/core/tdpl_pkg.sv
// Package with shared types and constants for the tile darkness block.
package tdpl_pkg;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_AMBIENT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE  = CSR_IDX_W'(1);

   localparam int unsigned DIV_W = 48;

   typedef struct packed {
      logic        start;
      logic        is_sqrt;
      logic [63:0] num;
      logic [23:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quot;
   } div_rsp_type;
endpackage

FILE: rtl/core/tdpl_serial_unit.sv
// Shared bit-serial unit: restoring division or square root, one result bit per cycle.
module tdpl_serial_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  tdpl_pkg::div_cmd_type cmd,
   output tdpl_pkg::div_rsp_type rsp
);
   import tdpl_pkg::*;

   logic [63:0] num_ff, num_in;
   logic [49:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [23:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        sq_ff, sq_in;
   logic        done_ff, done_in;
   logic [49:0] trial;
   logic [49:0] sub;
   logic        fits;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sq_in   = sq_ff;
      done_in = 1'b0;
      if (sq_ff) begin
         trial = {rem_ff[47:0], num_ff[63:62]};
         sub   = {quo_ff[47:0], 2'b01};
         num_in = {num_ff[61:0], 2'b00};
      end else begin
         trial = {rem_ff[48:0], num_ff[63]};
         sub   = {26'd0, den_ff};
         num_in = {num_ff[62:0], 1'b0};
      end
      fits = trial >= sub;
      if (cmd.start) begin
         num_in  = cmd.is_sqrt ? cmd.num : {cmd.num[47:0], 16'd0};
         den_in  = cmd.den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = cmd.is_sqrt ? 6'd32 : 6'd48;
         sq_in   = cmd.is_sqrt;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial - sub : trial;
         quo_in = {quo_ff[46:0], fits};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         num_in = num_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      sq_ff  <= sq_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !done_in |=> busy_ff || done_ff) else $error("busy dropped");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
endmodule

FILE: rtl/core/tile_darkness_from_point_lights.sv
// Top level: per-tile darkness alpha from a run of point-light beats.
//  channel | dir | payload
//  req     | in  | tile, light and run marks
//  rsp     | out | alpha on the last beat of a tile
//  csr     | in  | ambient_max_alpha, ignore_lights
// A full light beat runs a 32-step square root and three 48-step divisions, one after
// another in the shared serial unit, before the next beat is accepted. Beats without an
// overlapping light skip the serial unit; a light that stops early skips the later steps.
// Reset is synchronous and clears the control and tile state, not the datapath registers.
// A pending result holds only a finished last beat in its final state until rsp is taken.
module tile_darkness_from_point_lights #(
   parameter int TILE_PIXELS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // tile_x, tile_y, tile_max_alpha, light_x, light_y,
                                    // light_distance, light_strength, light_present, pad
   input  logic         req_tuser,  // first_of_tile
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // alpha
   input  logic         csr_wr_en,
   input  logic [tdpl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tdpl_pkg::CSR_DATA_W-1:0] csr_data
);
   import tdpl_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHK  = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_DIV1 = 3'd3;
   localparam logic [2:0] ST_DIV2 = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;
   localparam logic [2:0] ST_FRAC = 3'd6;
   localparam int QUART = TILE_PIXELS / 4;

   logic [2:0]  st_ff, st_in;
   logic [7:0]  amb_ff;
   logic        ign_ff;
   logic [7:0]  min_ff, min_in;
   logic [7:0]  lim_ff, lim_in;
   logic signed [15:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [15:0] lx_ff, ly_ff;
   logic [15:0] dist_ff, str_ff;
   logic        last_ff, pres_ff;
   logic [31:0] d_ff;
   logic [47:0] amt_ff;
   logic [7:0]  out_ff;
   logic        ov_ff;
   div_cmd_type cmd;
   div_rsp_type rsp;
   logic        acc;
   logic        out_free;
   logic [7:0]  tmax, base_lim, v;
   logic        v_ok;
   logic signed [24:0] holdv, half, span, bx, by;
   logic signed [20:0] hx;
   logic signed [24:0] dx, dy;
   logic [33:0] sq;
   logic [23:0] frac, denom;

   tdpl_serial_unit u_su (.clock(clock), .reset(reset), .cmd(cmd), .rsp(rsp));

   assign acc = req_tvalid && req_tready;
   assign out_free = !ov_ff || rsp_tready;
   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;
   assign tmax = req_tdata[39:32];
   assign base_lim = (amb_ff < tmax) ? amb_ff : tmax;

   always_comb begin
      hx    = {5'd0, dist_ff} * 21'sd10;
      holdv = {4'd0, hx[20:8] | 13'd1} + 25'sd1;
      half  = 25'((holdv >>> 1) * TILE_PIXELS);
      span  = 25'(holdv * TILE_PIXELS);
      bx    = 25'(lx_ff) - half;
      by    = 25'(ly_ff) - half;
      dx    = 25'(tx_ff) + 25'(QUART) - 25'(lx_ff);
      dy    = 25'(ty_ff) + 25'(QUART) - 25'(ly_ff);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq    = {17'd0, dx[16:0]} * {17'd0, dx[16:0]} + {17'd0, dy[16:0]} * {17'd0, dy[16:0]};
      frac  = rsp.quot[23:0];
      denom = (frac > {8'd0, str_ff}) ? 24'd0 : {8'd0, str_ff} - frac;
   end

   always_comb begin
      st_in  = st_ff;
      min_in = min_ff;
      lim_in = lim_ff;
      tx_in  = tx_ff;
      ty_in  = ty_ff;
      cmd    = '0;
      v      = lim_ff;
      v_ok   = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (acc) begin
            if (req_tuser) begin
               tx_in  = req_tdata[15:0];
               ty_in  = req_tdata[31:16];
               lim_in = base_lim;
               min_in = base_lim;
            end
            st_in = ST_CHK;
         end
         ST_CHK: begin
            if (!pres_ff || ign_ff) st_in = ST_DONE;
            else if (!(25'(tx_ff) < bx + span && bx < 25'(tx_ff) + TILE_PIXELS) ||
                     !(25'(ty_ff) < by + span && by < 25'(ty_ff) + TILE_PIXELS)) begin
               st_in = ST_DONE;
            end else begin
               cmd.start = 1'b1;
               cmd.is_sqrt = 1'b1;
               cmd.num = {14'd0, sq, 16'd0};
               st_in = ST_SQRT;
            end
         end
         ST_SQRT: if (rsp.done) begin
            if (str_ff == 16'd0) begin
               v_ok = 1'b1;
               st_in = ST_DONE;
            end else begin
               cmd.start = 1'b1;
               cmd.num = {24'd0, rsp.quot[31:0], 8'd0};
               cmd.den = {8'd0, str_ff};
               st_in = ST_DIV1;
            end
         end
         ST_DIV1: if (rsp.done) begin
            if (rsp.quot >= {32'd0, lim_ff, 8'd0}) begin
               v_ok = 1'b1;
               st_in = ST_DONE;
            end else begin
               cmd.start = 1'b1;
               cmd.num = {32'd0, d_ff};
               cmd.den = 24'd250;
               st_in = ST_FRAC;
            end
         end
         ST_FRAC: if (rsp.done) begin
            if (denom == 24'd0) begin
               v_ok = 1'b1;
               st_in = ST_DONE;
            end else begin
               cmd.start = 1'b1;
               cmd.num = {8'd0, amt_ff, 8'd0};
               cmd.den = denom;
               st_in = ST_DIV2;
            end
         end
         ST_DIV2: if (rsp.done) begin
            v = (rsp.quot > {32'd0, lim_ff, 8'd0}) ? lim_ff : rsp.quot[15:8];
            v_ok = 1'b1;
            st_in = ST_DONE;
         end
         ST_DONE: if (!last_ff || out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
      if (v_ok && v < min_ff) min_in = v;
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         lx_ff   <= req_tdata[55:40];
         ly_ff   <= req_tdata[71:56];
         dist_ff <= req_tdata[87:72];
         str_ff  <= req_tdata[103:88];
         pres_ff <= req_tdata[104];
         last_ff <= req_tlast;
      end
      if (st_ff == ST_SQRT && rsp.done) d_ff <= rsp.quot[31:0];
      if (st_ff == ST_DIV1 && rsp.done) amt_ff <= rsp.quot;
      if (st_ff == ST_DONE && last_ff && out_free) out_ff <= min_ff;
      if (reset) begin
         st_ff  <= ST_IDLE;
         amb_ff <= 8'd255;
         ign_ff <= 1'b0;
         min_ff <= '0;
         lim_ff <= '0;
         tx_ff  <= '0;
         ty_ff  <= '0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         min_ff <= min_in;
         lim_ff <= lim_in;
         tx_ff  <= tx_in;
         ty_ff  <= ty_in;
         if (csr_wr_en && csr_index == CSR_IDX_W'(CSR_AMBIENT)) amb_ff <= csr_data;
         if (csr_wr_en && csr_index == CSR_IDX_W'(CSR_IGNORE)) ign_ff <= csr_data[0];
         if (st_ff == ST_DONE && last_ff && out_free) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
   end

   a_min_le_lim: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DONE |-> min_ff <= lim_ff) else $error("minimum above limit");
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !req_tready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule
